[rtl/core/sliding_median_of_five_unit_assert.svh]
// assertion macros used by the median filter rtl
// expects clk and rst in the scope of the module that includes it
`ifndef SLIDING_MEDIAN_OF_FIVE_UNIT_ASSERT_SVH
`define SLIDING_MEDIAN_OF_FIVE_UNIT_ASSERT_SVH

// property that holds in every cycle out of reset
`define SMF_CHECK(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("median filter check failed");

// consequence that must hold in the cycle after the trigger
`define SMF_CHECK_NEXT(label, trig, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error("median filter check failed");

`endif

[rtl/core/smf_pkg.sv]
// shared widths, defaults and the link type between window cells
// used by every module of the median filter
package smf_pkg;

  localparam int unsigned SAMPLE_W        = 16;
  localparam int unsigned WINDOW_SIZE_DEF = 5;
  localparam int unsigned RANK_W          = 4;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [RANK_W-1:0]   rank_t;

  typedef struct packed {
    sample_t value;
    rank_t   rank;
    rank_t   rank_adj;
    logic    lt_new;
    logic    hit_next;
    logic    hit_now;
  } cell_link_t;

endpackage

[rtl/core/smf_cell.sv]
// one window cell: a stored sample and its sorted rank
// depends on smf_pkg; the top level chains these newest to oldest
module smf_cell #(
  parameter int unsigned CELL_IDX = 0,
  parameter int unsigned MID      = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                shift,
  input  smf_pkg::sample_t    in_value,
  input  smf_pkg::rank_t      in_rank,
  input  smf_pkg::sample_t    sample,
  input  smf_pkg::sample_t    oldest,
  output smf_pkg::cell_link_t link
);

  smf_pkg::sample_t value;
  smf_pkg::rank_t   rank;
  smf_pkg::rank_t   rank_adj;

  always_ff @(posedge clk) begin
    if (rst) begin
      value <= '0;
      rank  <= smf_pkg::rank_t'(CELL_IDX);
    end else if (shift) begin
      value <= in_value;
      rank  <= in_rank;
    end
  end

  // oldest leaves (ties rank it above), new sample enters (ties rank it below)
  always_comb begin
    rank_adj = rank - smf_pkg::rank_t'(oldest < value)
                    + smf_pkg::rank_t'(sample <= value);
  end

  assign link.value    = value;
  assign link.rank     = rank;
  assign link.rank_adj = rank_adj;
  assign link.lt_new   = (value < sample);
  assign link.hit_next = (rank_adj == smf_pkg::rank_t'(MID));
  assign link.hit_now  = (rank == smf_pkg::rank_t'(MID));

endmodule

[rtl/core/smf_outq.sv]
// two-entry result queue between the cell chain and the median port
// depends on smf_pkg
module smf_outq (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  smf_pkg::sample_t push_data,
  output logic             in_ready,
  output logic             valid,
  output smf_pkg::sample_t data,
  input  logic             ready
);

  logic [1:0]       count;
  logic [1:0]       count_next;
  smf_pkg::sample_t slot0;
  smf_pkg::sample_t slot1;
  logic             pop;

  assign pop      = valid && ready;
  assign valid    = (count != 2'd0);
  assign in_ready = (count != 2'd2);
  assign data     = slot0;

  always_comb begin
    count_next = count + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= 2'd0;
    end else begin
      count <= count_next;
    end
  end

  always_ff @(posedge clk) begin
    if (count == 2'd2 && pop) begin
      slot0 <= slot1;
    end else if (push && (count == 2'd0 || (count == 2'd1 && pop))) begin
      slot0 <= push_data;
    end
    if (push && count == 2'd1 && !pop) begin
      slot1 <= push_data;
    end
  end

endmodule

[rtl/core/sliding_median_of_five_unit.sv]
// Running median filter over the last WINDOW_SIZE samples. One sample is
// taken per clock cycle while the two-entry result queue has room, which
// lets requests keep flowing while a result waits; each median is queued
// for the result port. The window is a chain of cells, one per sample, each
// keeping its sorted rank, so an insert updates the whole window at once.
// After reset the window holds zeros, which count toward early medians.
// top level; depends on smf_pkg, smf_cell, smf_outq and the assert header
`include "sliding_median_of_five_unit_assert.svh"

module sliding_median_of_five_unit #(
  parameter int unsigned WINDOW_SIZE = smf_pkg::WINDOW_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  smf_pkg::sample_t sample,
  input  logic             sample_valid,
  output logic             sample_ready,
  output smf_pkg::sample_t median,
  output logic             median_valid,
  input  logic             median_ready
);

  localparam int unsigned MID = WINDOW_SIZE / 2;

  smf_pkg::cell_link_t    link [WINDOW_SIZE];
  smf_pkg::rank_t         rank_s;
  logic                   hit_s;
  logic                   accept;
  smf_pkg::sample_t       median_next;
  logic [WINDOW_SIZE-1:0] hit_next_vec;
  logic [WINDOW_SIZE-1:0] hit_now_vec;

  assign accept = sample_valid && sample_ready;

  for (genvar i = 0; i < WINDOW_SIZE; i++) begin : g_cell
    smf_pkg::sample_t in_value;
    smf_pkg::rank_t   in_rank;
    if (i == 0) begin : g_head
      assign in_value = sample;
      assign in_rank  = rank_s;
    end else begin : g_body
      assign in_value = link[i-1].value;
      assign in_rank  = link[i-1].rank_adj;
    end

    smf_cell #(
      .CELL_IDX(i),
      .MID     (MID)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .shift   (accept),
      .in_value(in_value),
      .in_rank (in_rank),
      .sample  (sample),
      .oldest  (link[WINDOW_SIZE-1].value),
      .link    (link[i])
    );

    assign hit_now_vec[i] = link[i].hit_now;
  end

  // rank of the incoming sample among the survivors
  always_comb begin
    rank_s = '0;
    for (int i = 0; i < WINDOW_SIZE - 1; i++) begin
      rank_s = rank_s + smf_pkg::rank_t'(link[i].lt_new);
    end
  end

  assign hit_s = (rank_s == smf_pkg::rank_t'(MID));

  always_comb begin
    hit_next_vec[0] = hit_s;
    median_next     = hit_s ? sample : '0;
    for (int i = 0; i < WINDOW_SIZE - 1; i++) begin
      hit_next_vec[i+1] = link[i].hit_next;
      if (link[i].hit_next) begin
        median_next = median_next | link[i].value;
      end
    end
  end

  smf_outq u_outq (
    .clk      (clk),
    .rst      (rst),
    .push     (accept),
    .push_data(median_next),
    .in_ready (sample_ready),
    .valid    (median_valid),
    .data     (median),
    .ready    (median_ready)
  );

  `SMF_CHECK(a_rank_now_unique, $onehot(hit_now_vec))
  `SMF_CHECK(a_rank_next_unique, $onehot(hit_next_vec))
  `SMF_CHECK_NEXT(a_request_gives_result, accept, median_valid)

endmodule

[bench/tb_top.sv]
// testbench for sliding_median_of_five_unit: directed and random sample streams
// with random gaps and stalls on both channels, checked against a median tracker
// depends on smf_pkg and the rtl of sliding_median_of_five_unit
module tb_top;

  localparam int WIN = smf_pkg::WINDOW_SIZE_DEF;
  localparam int RANDOM_SAMPLES = 1530;
  localparam int LONG_HOLD_CYCLES = 120;

  class median_tracker;
    smf_pkg::sample_t history[WIN];
    smf_pkg::sample_t expected_medians[$];
    int unsigned      errors;

    function new();
      foreach (history[i]) history[i] = '0;
      errors = 0;
    endfunction

    function smf_pkg::sample_t median_after_insert(smf_pkg::sample_t s);
      smf_pkg::sample_t ordered[WIN];
      smf_pkg::sample_t key;
      int               j;
      for (int i = WIN - 1; i > 0; i--) history[i] = history[i-1];
      history[0] = s;
      ordered = history;
      for (int i = 1; i < WIN; i++) begin
        key = ordered[i];
        j = i - 1;
        while (j >= 0 && ordered[j] > key) begin
          ordered[j+1] = ordered[j];
          j--;
        end
        ordered[j+1] = key;
      end
      return ordered[WIN/2];
    endfunction

    function void note_sample(smf_pkg::sample_t s);
      expected_medians.push_back(median_after_insert(s));
    endfunction

    function void check_median(smf_pkg::sample_t got);
      smf_pkg::sample_t want;
      if (expected_medians.size() == 0) begin
        $error("median: unexpected result, actual %0d", got);
        errors++;
      end else begin
        want = expected_medians.pop_front();
        if (got !== want) begin
          $error("median: expected %0d, actual %0d", want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return expected_medians.size();
    endfunction
  endclass

  logic             clk;
  logic             rst;
  smf_pkg::sample_t sample;
  logic             sample_valid;
  logic             sample_ready;
  smf_pkg::sample_t median;
  logic             median_valid;
  logic             median_ready;

  median_tracker tracker;
  bit            quiet_sender;
  bit            quiet_receiver;
  bit            long_hold;

  sliding_median_of_five_unit uut (
    .clk          (clk),
    .rst          (rst),
    .sample       (sample),
    .sample_valid (sample_valid),
    .sample_ready (sample_ready),
    .median       (median),
    .median_valid (median_valid),
    .median_ready (median_ready)
  );

  always begin
    clk = 1'b0;
    #2;
    clk = 1'b1;
    #2;
  end

  always @(posedge clk) begin
    if (!rst) begin
      if (sample_valid && sample_ready) tracker.note_sample(sample);
      if (median_valid && median_ready) tracker.check_median(median);
    end
  end

  task automatic send_sample(input smf_pkg::sample_t v);
    int gap;
    gap = quiet_sender ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      sample_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    sample       <= v;
    sample_valid <= 1'b1;
    do @(posedge clk); while (!sample_ready);
    @(negedge clk);
  endtask

  // receiver: random stalls, quiet stretches and one long hold-off
  initial begin
    int stall;
    int taken;
    median_ready = 1'b0;
    taken = 0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      if (long_hold) begin
        median_ready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
      end else begin
        stall = quiet_receiver ? 0 : $urandom_range(0, 11);
        if (stall > 0) begin
          median_ready <= 1'b0;
          repeat (stall) @(negedge clk);
        end
      end
      median_ready <= 1'b1;
      do @(posedge clk); while (!(median_valid && median_ready));
      taken++;
      if (taken % 64 == 0) quiet_receiver = ($urandom_range(0, 3) == 0);
      @(negedge clk);
    end
  end

  initial begin
    #2000000;
    $display("sliding_median_of_five_unit test failed");
    $finish;
  end

  initial begin
    smf_pkg::sample_t directed[$];
    smf_pkg::sample_t prev;
    int               mode;
    int               next;
    tracker        = new();
    rst            = 1'b1;
    sample         = '0;
    sample_valid   = 1'b0;
    quiet_sender   = 1'b0;
    quiet_receiver = 1'b0;
    long_hold      = 1'b0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // start-up zeros, extremes, bit patterns, ties, falling run
    directed = '{16'd1, 16'd2, 16'd3, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'h0000,
                 16'h0000, 16'h0000, 16'h8000, 16'h7FFF, 16'hAAAA, 16'h5555,
                 16'd5, 16'd5, 16'd5, 16'd5, 16'd5, 16'd50, 16'd40, 16'd30,
                 16'd20, 16'd10, 16'hFFFF};
    foreach (directed[i]) send_sample(directed[i]);

    prev = directed[$];
    for (int n = 0; n < RANDOM_SAMPLES; n++) begin
      if (n % 100 == 0) quiet_sender = ($urandom_range(0, 3) == 0);
      if (n == 700) begin
        quiet_sender = 1'b1;
        long_hold    = 1'b1;
      end
      if (n == 760) quiet_sender = 1'b0;
      mode = $urandom_range(0, 9);
      case (mode)
        0, 1, 2, 3: next = $urandom_range(0, 16'hFFFF);
        4, 5: next = $urandom_range(0, 7);
        6: begin
          case ($urandom_range(0, 3))
            0: next = 16'h0000;
            1: next = 16'hFFFF;
            2: next = 16'h7FFF;
            default: next = 16'h8000;
          endcase
        end
        7: next = prev;
        default: begin
          next = int'(prev) + $urandom_range(0, 64) - 32;
          if (next < 0) next = 0;
          if (next > 16'hFFFF) next = 16'hFFFF;
        end
      endcase
      prev = smf_pkg::sample_t'(next);
      send_sample(prev);
    end
    sample_valid <= 1'b0;

    while (tracker.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (tracker.errors == 0) begin
      $display("sliding_median_of_five_unit test passed");
    end else begin
      $display("sliding_median_of_five_unit test failed");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+rtl/core
rtl/core/smf_pkg.sv
rtl/core/smf_cell.sv
rtl/core/smf_outq.sv
rtl/core/sliding_median_of_five_unit.sv
bench/tb_top.sv
